### rtl/segdist_pkg.sv
// Shared constants and types of the segment-to-segment distance pipeline.
`default_nettype none

package segdist_pkg;

  localparam int CW          = 20;
  localparam int NIN         = 12;
  localparam int DW          = CW + 1;
  localparam int PW          = 2 * DW;
  localparam int SW          = PW + 2;
  localparam int WW          = 2 * SW;
  localparam int MH          = SW / 2;
  localparam int CFRAC       = 4;
  localparam int PFRAC       = 16;
  localparam int QW          = PFRAC + 1;
  localparam int DIV_STEPS   = PFRAC;
  localparam int PRW         = DW + QW + 2;
  localparam int SQH         = PRW / 2;
  localparam int SQW         = 2 * PRW;
  localparam int SUMW        = SQW + 2;
  localparam int OW          = 21;
  localparam int XW          = 2 * OW;
  localparam int RW          = XW + 2;
  localparam int TW          = 16;
  localparam int SQ_SH       = TW - 2 * CFRAC;
  localparam int SQ_LIM_ADD  = (1 << SQ_SH) - 1;
  localparam int TDATA_IN_W  = ((NIN * CW + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((OW + 7) / 8) * 8;
  localparam int CFG_IW      = 1;

  localparam logic [TW-1:0] THR_RESET = TW'(66);

  localparam logic [CFG_IW-1:0] REG_PARALLEL = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_ZERO     = CFG_IW'(1);

  // Fractional scale of a numerator/denominator pair
  localparam logic [1:0] FR_NONE = 2'd0;
  localparam logic [1:0] FR_SQ   = 2'd1;
  localparam logic [1:0] FR_QUAD = 2'd2;

  typedef struct packed {
    logic [2:0][DW-1:0] u;
    logic [2:0][DW-1:0] v;
    logic [2:0][DW-1:0] w;
  } geo_t;

  typedef struct packed {
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [SW-1:0] c;
    logic [SW-1:0] d;
    logic [SW-1:0] e;
  } dot_t;

  typedef struct packed {
    logic [WW-1:0] sn;
    logic [WW-1:0] sd;
    logic [WW-1:0] tn;
    logic [WW-1:0] td;
    logic [1:0]    sfr;
    logic [1:0]    tfr;
  } sel_t;

  typedef struct packed {
    logic zero;
    logic one;
  } div_flags_t;

endpackage

`default_nettype wire

### rtl/segdist_mul.sv
// Two-stage signed multiplier built from two half-width partial products.
`default_nettype none

module segdist_mul (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [segdist_pkg::SW-1:0]      a_i,
  input  wire logic [segdist_pkg::SW-1:0]      b_i,
  output logic      [segdist_pkg::WW-1:0]      p_o
);

  localparam int LW = segdist_pkg::SW + segdist_pkg::MH + 1;
  localparam int HW = 2 * segdist_pkg::SW - segdist_pkg::MH;

  logic signed [LW-1:0]             pl_q;
  logic signed [HW-1:0]             ph_q;
  logic        [segdist_pkg::WW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= $signed(a_i) * $signed({1'b0, b_i[segdist_pkg::MH-1:0]});
      ph_q <= $signed(a_i) * $signed(b_i[segdist_pkg::SW-1:segdist_pkg::MH]);
      p_q  <= (segdist_pkg::WW'(ph_q) << segdist_pkg::MH) + segdist_pkg::WW'(pl_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/segdist_div.sv
// Pipelined restoring divider giving a clamped ratio, one quotient bit per stage.
`default_nettype none

module segdist_div (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [segdist_pkg::WW-1:0]   num_i,
  input  wire logic [segdist_pkg::WW-1:0]   den_i,
  input  wire segdist_pkg::div_flags_t      flags_i,
  output logic      [segdist_pkg::QW-1:0]   ratio_o
);

  localparam int N  = segdist_pkg::DIV_STEPS;
  localparam int WW = segdist_pkg::WW;
  localparam int FR = segdist_pkg::PFRAC;

  logic [WW-1:0]           rem_q [N];
  logic [WW-1:0]           den_q [N];
  logic [FR-1:0]           quo_q [N];
  segdist_pkg::div_flags_t flg_q [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    logic [WW-1:0]           rem_in;
    logic [WW-1:0]           den_in;
    logic [FR-1:0]           quo_in;
    segdist_pkg::div_flags_t flg_in;
    logic [WW-1:0]           shl;
    logic                    ge;

    if (gi == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign flg_in = flags_i;
    end else begin : g_next
      assign rem_in = rem_q[gi-1];
      assign den_in = den_q[gi-1];
      assign quo_in = quo_q[gi-1];
      assign flg_in = flg_q[gi-1];
    end

    assign shl = {rem_in[WW-2:0], 1'b0};
    assign ge  = (shl >= den_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi] <= ge ? (shl - den_in) : shl;
        den_q[gi] <= den_in;
        quo_q[gi] <= {quo_in[FR-2:0], ge};
        flg_q[gi] <= flg_in;
      end
    end
  end

  always_comb begin
    if (flg_q[N-1].zero) begin
      ratio_o = '0;
    end else if (flg_q[N-1].one) begin
      ratio_o = {1'b1, {FR{1'b0}}};
    end else begin
      ratio_o = {1'b0, quo_q[N-1]};
    end
  end

endmodule

`default_nettype wire

### rtl/segdist_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module segdist_isqrt (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [segdist_pkg::XW-1:0]   x_i,
  output logic      [segdist_pkg::OW-1:0]   root_o
);

  localparam int N  = segdist_pkg::OW;
  localparam int RW = segdist_pkg::RW;

  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    localparam int K = N - 1 - gi;
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [RW-1:0] trial;
    logic          ge;

    if (gi == 0) begin : g_first
      assign rem_in  = RW'(x_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[gi-1];
      assign root_in = root_q[gi-1];
    end

    assign trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi]  <= ge ? (rem_in - trial) : rem_in;
        root_q[gi] <= root_in | (N'(ge) << K);
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

`default_nettype wire

### rtl/segment_to_segment_distance.sv
// Top level: closest distance between two 3D segments, fully pipelined.
//
// Usage:
//   Slave stream carries one item per segment pair: twelve signed Q16.4
//   coordinates. Master stream returns one item per pair: the distance in
//   unsigned Q17.4, saturated to 21 bits.
//   The configuration port writes the parallel and zero thresholds
//   (Q.16); write them only while no item is in flight.
//   From input accept to output valid an item passes the differences, dot
//   products, wide products and case selection, then the divider (one
//   quotient bit per stage), then the distance vector and its squared
//   length, then the square root. Throughput is one item per cycle while
//   the output is not stalled.
//   All stages advance together: when the output holds an item that the
//   receiver does not take, the whole pipeline holds and s_axis_tready_o
//   drops; nothing is lost or repeated.
//   Reset empties the pipeline and sets both thresholds to 66.
`default_nettype none

module segment_to_segment_distance (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [segdist_pkg::CFG_IW-1:0]         cfg_idx_i,
  input  wire logic [segdist_pkg::TW-1:0]             cfg_data_i,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  wire logic [segdist_pkg::TDATA_IN_W-1:0]     s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // closest_distance, zero fill above
  output logic      [segdist_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o
);

  localparam int CW    = segdist_pkg::CW;
  localparam int DW    = segdist_pkg::DW;
  localparam int PW    = segdist_pkg::PW;
  localparam int SW    = segdist_pkg::SW;
  localparam int WW    = segdist_pkg::WW;
  localparam int TW    = segdist_pkg::TW;
  localparam int QW    = segdist_pkg::QW;
  localparam int PRW   = segdist_pkg::PRW;
  localparam int SQH   = segdist_pkg::SQH;
  localparam int SQW   = segdist_pkg::SQW;
  localparam int SUMW  = segdist_pkg::SUMW;
  localparam int XW    = segdist_pkg::XW;
  localparam int OW    = segdist_pkg::OW;
  localparam int PFRAC = segdist_pkg::PFRAC;
  localparam int GEO_N = 9 + segdist_pkg::DIV_STEPS;
  localparam int NST   = GEO_N + 5 + OW;

  function automatic logic below(input logic [WW-1:0] n, input logic [1:0] fr,
                                 input logic [TW-1:0] thr);
    logic [WW-1:0] mag;
    logic [TW:0]   lim;
    mag = n[WW-1] ? (~n + WW'(1)) : n;
    unique case (fr)
      segdist_pkg::FR_QUAD: lim = {1'b0, thr};
      segdist_pkg::FR_SQ:   lim = ({1'b0, thr} + (TW+1)'(segdist_pkg::SQ_LIM_ADD))
                                  >> segdist_pkg::SQ_SH;
      segdist_pkg::FR_NONE: lim = (TW+1)'(thr != '0);
      default:              lim = '0;
    endcase
    return mag < WW'(lim);
  endfunction

  logic            adv;
  logic [NST-1:0]  vld_q;
  logic [TW-1:0]   pthr_q, zthr_q;

  segdist_pkg::geo_t geo_q [GEO_N];
  logic [PW-1:0]     uu_q [3], uv_q [3], vv_q [3], uw_q [3], vw_q [3];
  segdist_pkg::dot_t dot_q;
  segdist_pkg::dot_t dot_dly_q [4];
  logic [WW-1:0]     ac_w, bb_w, be_w, cd_w, ae_w, bd_w;
  logic [WW-1:0]     dd_q, snr_q, tnr_q;
  segdist_pkg::sel_t sel7_d, sel7_q, sel8_d, sel8_q;
  logic [WW-1:0]     sn9_q, sd9_q, tn9_q, td9_q;
  segdist_pkg::div_flags_t sf9_q, tf9_q;
  logic [QW-1:0]     sc_w, tc_w;
  logic [PRW-1:0]    us_q [3], vt_q [3], ws_q [3];
  logic [PRW-1:0]    mag_q [3];
  logic [SQW-SQH-1:0] pl_q [3], ph_q [3];
  logic [SQW-1:0]    sq_q [3];
  logic [SUMW-1:0]   sum_w;
  logic [XW-1:0]     x_q;
  logic [OW-1:0]     root_w;

  assign adv             = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NST-1];
  assign m_axis_tdata_o  = segdist_pkg::TDATA_OUT_W'(root_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      pthr_q <= segdist_pkg::THR_RESET;
      zthr_q <= segdist_pkg::THR_RESET;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NST-2:0], s_axis_tvalid_i};
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          segdist_pkg::REG_PARALLEL: pthr_q <= cfg_data_i;
          segdist_pkg::REG_ZERO:     zthr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Differences, products, dot products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        geo_q[0].u[i] <= DW'($signed(s_axis_tdata_i[(3+i)*CW +: CW]))
                       - DW'($signed(s_axis_tdata_i[i*CW +: CW]));
        geo_q[0].v[i] <= DW'($signed(s_axis_tdata_i[(9+i)*CW +: CW]))
                       - DW'($signed(s_axis_tdata_i[(6+i)*CW +: CW]));
        geo_q[0].w[i] <= DW'($signed(s_axis_tdata_i[i*CW +: CW]))
                       - DW'($signed(s_axis_tdata_i[(6+i)*CW +: CW]));
        uu_q[i] <= $signed(geo_q[0].u[i]) * $signed(geo_q[0].u[i]);
        uv_q[i] <= $signed(geo_q[0].u[i]) * $signed(geo_q[0].v[i]);
        vv_q[i] <= $signed(geo_q[0].v[i]) * $signed(geo_q[0].v[i]);
        uw_q[i] <= $signed(geo_q[0].u[i]) * $signed(geo_q[0].w[i]);
        vw_q[i] <= $signed(geo_q[0].v[i]) * $signed(geo_q[0].w[i]);
      end
      for (int k = 1; k < GEO_N; k++) begin
        geo_q[k] <= geo_q[k-1];
      end
      dot_q.a <= SW'($signed(uu_q[0])) + SW'($signed(uu_q[1])) + SW'($signed(uu_q[2]));
      dot_q.b <= SW'($signed(uv_q[0])) + SW'($signed(uv_q[1])) + SW'($signed(uv_q[2]));
      dot_q.c <= SW'($signed(vv_q[0])) + SW'($signed(vv_q[1])) + SW'($signed(vv_q[2]));
      dot_q.d <= SW'($signed(uw_q[0])) + SW'($signed(uw_q[1])) + SW'($signed(uw_q[2]));
      dot_q.e <= SW'($signed(vw_q[0])) + SW'($signed(vw_q[1])) + SW'($signed(vw_q[2]));
      dot_dly_q[0] <= dot_q;
      for (int k = 1; k < 4; k++) begin
        dot_dly_q[k] <= dot_dly_q[k-1];
      end
    end
  end

  segdist_mul u_mul_ac (.clk_i, .en_i(adv), .a_i(dot_q.a), .b_i(dot_q.c), .p_o(ac_w));
  segdist_mul u_mul_bb (.clk_i, .en_i(adv), .a_i(dot_q.b), .b_i(dot_q.b), .p_o(bb_w));
  segdist_mul u_mul_be (.clk_i, .en_i(adv), .a_i(dot_q.b), .b_i(dot_q.e), .p_o(be_w));
  segdist_mul u_mul_cd (.clk_i, .en_i(adv), .a_i(dot_q.c), .b_i(dot_q.d), .p_o(cd_w));
  segdist_mul u_mul_ae (.clk_i, .en_i(adv), .a_i(dot_q.a), .b_i(dot_q.e), .p_o(ae_w));
  segdist_mul u_mul_bd (.clk_i, .en_i(adv), .a_i(dot_q.b), .b_i(dot_q.d), .p_o(bd_w));

  // Parallel fallback and s clamp
  always_comb begin
    logic signed [WW-1:0] dd, snr, bw, cw, ew;
    dd  = $signed(dd_q);
    snr = $signed(snr_q);
    bw  = WW'($signed(dot_dly_q[2].b));
    cw  = WW'($signed(dot_dly_q[2].c));
    ew  = WW'($signed(dot_dly_q[2].e));
    if (below(dd_q, segdist_pkg::FR_QUAD, pthr_q)) begin
      sel7_d.sn  = '0;
      sel7_d.sd  = WW'(1);
      sel7_d.sfr = segdist_pkg::FR_NONE;
      sel7_d.tn  = ew;
      sel7_d.td  = cw;
      sel7_d.tfr = segdist_pkg::FR_SQ;
    end else begin
      sel7_d.sn  = snr_q;
      sel7_d.sd  = dd_q;
      sel7_d.sfr = segdist_pkg::FR_QUAD;
      sel7_d.tn  = tnr_q;
      sel7_d.td  = dd_q;
      sel7_d.tfr = segdist_pkg::FR_QUAD;
      if (snr < 0) begin
        sel7_d.sn  = '0;
        sel7_d.tn  = ew;
        sel7_d.td  = cw;
        sel7_d.tfr = segdist_pkg::FR_SQ;
      end else if (dd < snr) begin
        sel7_d.sn  = dd_q;
        sel7_d.tn  = ew + bw;
        sel7_d.td  = cw;
        sel7_d.tfr = segdist_pkg::FR_SQ;
      end
    end
  end

  // t clamp, then s onto the matching endpoint
  always_comb begin
    logic signed [WW-1:0] aw, bw, dw, tn, td, q;
    logic                 clamp;
    aw    = WW'($signed(dot_dly_q[3].a));
    bw    = WW'($signed(dot_dly_q[3].b));
    dw    = WW'($signed(dot_dly_q[3].d));
    tn    = $signed(sel7_q.tn);
    td    = $signed(sel7_q.td);
    q     = -dw;
    clamp = 1'b0;
    sel8_d = sel7_q;
    if (tn < 0) begin
      sel8_d.tn = '0;
      clamp     = 1'b1;
    end else if (td < tn) begin
      sel8_d.tn = sel7_q.td;
      q         = bw - dw;
      clamp     = 1'b1;
    end
    if (clamp) begin
      if (q < 0) begin
        sel8_d.sn = '0;
      end else if (aw < q) begin
        sel8_d.sn = sel7_q.sd;
      end else begin
        sel8_d.sn  = q;
        sel8_d.sd  = aw;
        sel8_d.sfr = segdist_pkg::FR_SQ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q   <= ac_w - bb_w;
      snr_q  <= be_w - cd_w;
      tnr_q  <= ae_w - bd_w;
      sel7_q <= sel7_d;
      sel8_q <= sel8_d;
      sn9_q  <= sel8_q.sn;
      sd9_q  <= sel8_q.sd;
      tn9_q  <= sel8_q.tn;
      td9_q  <= sel8_q.td;
      sf9_q.zero <= below(sel8_q.sn, sel8_q.sfr, zthr_q) || sel8_q.sn[WW-1]
                    || sel8_q.sd[WW-1] || (sel8_q.sd == '0);
      sf9_q.one  <= !($signed(sel8_q.sn) < $signed(sel8_q.sd));
      tf9_q.zero <= below(sel8_q.tn, sel8_q.tfr, zthr_q) || sel8_q.tn[WW-1]
                    || sel8_q.td[WW-1] || (sel8_q.td == '0);
      tf9_q.one  <= !($signed(sel8_q.tn) < $signed(sel8_q.td));
    end
  end

  segdist_div u_div_s (.clk_i, .en_i(adv), .num_i(sn9_q), .den_i(sd9_q),
                       .flags_i(sf9_q), .ratio_o(sc_w));
  segdist_div u_div_t (.clk_i, .en_i(adv), .num_i(tn9_q), .den_i(td9_q),
                       .flags_i(tf9_q), .ratio_o(tc_w));

  // Difference vector and its squared length
  assign sum_w = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        us_q[i] <= PRW'($signed(geo_q[GEO_N-1].u[i]) * $signed({1'b0, sc_w}));
        vt_q[i] <= PRW'($signed(geo_q[GEO_N-1].v[i]) * $signed({1'b0, tc_w}));
        ws_q[i] <= PRW'($signed(geo_q[GEO_N-1].w[i])) << PFRAC;
        mag_q[i] <= ((ws_q[i] + us_q[i] - vt_q[i]) & {1'b1, {(PRW-1){1'b0}}}) != '0
                    ? PRW'(vt_q[i] - ws_q[i] - us_q[i])
                    : PRW'(ws_q[i] + us_q[i] - vt_q[i]);
        pl_q[i] <= mag_q[i] * mag_q[i][SQH-1:0];
        ph_q[i] <= mag_q[i] * mag_q[i][PRW-1:SQH];
        sq_q[i] <= (SQW'(ph_q[i]) << SQH) + SQW'(pl_q[i]);
      end
      x_q <= (sum_w[SUMW-1:2*PFRAC+XW] != '0) ? {XW{1'b1}} : sum_w[2*PFRAC +: XW];
    end
  end

  segdist_isqrt u_isqrt (.clk_i, .en_i(adv), .x_i(x_q), .root_o(root_w));

`ifndef SYNTHESIS
  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_ratio_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[GEO_N-1] |-> (sc_w <= {1'b1, {PFRAC{1'b0}}}) && (tc_w <= {1'b1, {PFRAC{1'b0}}}))
    else $error("segment parameter above one");

  a_parallel_s_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] && (sel7_q.sfr == segdist_pkg::FR_NONE) |->
      (sel7_q.sn == '0) && (sel7_q.sd == WW'(1)))
    else $error("parallel case with nonzero s");

  a_t_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> sel8_q.tfr != segdist_pkg::FR_NONE)
    else $error("t pair without scale");
`endif

endmodule

`default_nettype wire

### tb/sv/segment_to_segment_distance_checker.sv
// Checker: predicts closest segment distances and compares them with the output stream.
`timescale 1ns / 100ps

module segment_to_segment_distance_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [segdist_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  logic [segdist_pkg::TW-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  input  logic                                s_axis_tready_i,
  input  logic [segdist_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,
  input  logic                                m_axis_tvalid_i,
  input  logic                                m_axis_tready_i,
  input  logic [segdist_pkg::TDATA_OUT_W-1:0] m_axis_tdata_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam int CW          = segdist_pkg::CW;
  localparam int TW          = segdist_pkg::TW;
  localparam int CFRAC       = segdist_pkg::CFRAC;
  localparam int PFRAC       = segdist_pkg::PFRAC;
  localparam int TDATA_IN_W  = segdist_pkg::TDATA_IN_W;
  localparam int TDATA_OUT_W = segdist_pkg::TDATA_OUT_W;

  localparam logic [20:0] DIST_MAX = 21'h1FFFFF;

  logic [TW-1:0] par_thr_q, zero_thr_q;
  logic [20:0]   dist_q[$];

  assign pending_o = dist_q.size();

  // true when |n| / 2^frac < thr / 2^16
  function automatic bit is_small(logic signed [127:0] n, int frac, logic [TW-1:0] thr);
    logic signed [127:0] mag;
    mag = (n < 0) ? -n : n;
    return (mag <<< 16) < ({112'd0, thr} << frac);
  endfunction

  function automatic logic [16:0] param_div(logic signed [127:0] n, logic signed [127:0] d,
                                            int frac);
    logic [16:0] q;
    q = '0;
    if (is_small(n, frac, zero_thr_q)) return '0;
    if (n < 0 || d <= 0) return '0;
    if (n >= d) return 17'h10000;
    for (int i = 0; i < PFRAC; i++) begin
      n = n <<< 1;
      q = q << 1;
      if (n >= d) begin
        n = n - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [20:0] segment_distance(logic [TDATA_IN_W-1:0] data);
    logic signed [63:0] u[3], v[3], w[3], p[3];
    logic signed [63:0] a, b, c, d, e;
    logic signed [127:0] det, sn, sd, tn, td, q, sum;
    int sfr, tfr, i;
    bit clamp;
    logic [16:0] sc, tc;
    logic [127:0] len;
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (i = 0; i < 3; i++) begin
      u[i] = 64'(signed'(data[(3+i)*CW +: CW])) - 64'(signed'(data[i*CW +: CW]));
      v[i] = 64'(signed'(data[(9+i)*CW +: CW])) - 64'(signed'(data[(6+i)*CW +: CW]));
      w[i] = 64'(signed'(data[i*CW +: CW])) - 64'(signed'(data[(6+i)*CW +: CW]));
      a += u[i] * u[i]; b += u[i] * v[i]; c += v[i] * v[i];
      d += u[i] * w[i]; e += v[i] * w[i];
    end
    det = 128'(a) * 128'(c) - 128'(b) * 128'(b);
    if (is_small(det, 4 * CFRAC, par_thr_q)) begin
      sn = 0; sd = 1; sfr = 0;
      tn = e; td = c; tfr = 2 * CFRAC;
    end else begin
      sn = 128'(b) * 128'(e) - 128'(c) * 128'(d);
      tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
      sd = det; td = det; sfr = 4 * CFRAC; tfr = 4 * CFRAC;
      if (sn < 0) begin
        sn = 0; tn = e; td = c; tfr = 2 * CFRAC;
      end else if (sd < sn) begin
        sn = sd; tn = e + b; td = c; tfr = 2 * CFRAC;
      end
    end
    q = 0;
    clamp = 1'b0;
    if (tn < 0) begin
      tn = 0; q = -d; clamp = 1'b1;
    end else if (td < tn) begin
      tn = td; q = b - d; clamp = 1'b1;
    end
    if (clamp) begin
      if (q < 0) begin
        sn = 0;
      end else if (a < q) begin
        sn = sd;
      end else begin
        sn = q; sd = a; sfr = 2 * CFRAC;
      end
    end
    sc = param_div(sn, sd, sfr);
    tc = param_div(tn, td, tfr);
    sum = 0;
    for (i = 0; i < 3; i++) begin
      p[i] = w[i] * 64'sd65536 + u[i] * 64'(sc) - v[i] * 64'(tc);
      sum += 128'(p[i]) * 128'(p[i]);
    end
    sum = sum >>> (2 * PFRAC);
    len = (sum[127:64] != 0) ? 128'(DIST_MAX) : 128'(int_sqrt(sum[63:0]));
    return (len > DIST_MAX) ? DIST_MAX : len[20:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_thr_q <= segdist_pkg::THR_RESET;
      zero_thr_q <= segdist_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == segdist_pkg::REG_PARALLEL) par_thr_q <= cfg_data_i;
      else if (cfg_idx_i == segdist_pkg::REG_ZERO) zero_thr_q <= cfg_data_i;
    end
  end

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    logic [20:0] want;
    if (rst_ni && m_axis_tvalid_i && m_axis_tready_i) begin
      if (dist_q.size() == 0) begin
        fail_count_o++;
        if (fail_count_o <= 10) $display("unexpected item: %0d", m_axis_tdata_i[20:0]);
      end else begin
        want = dist_q.pop_front();
        if (m_axis_tdata_i != TDATA_OUT_W'(want)) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("closest_distance mismatch: expected %0d got %0d", want,
                     m_axis_tdata_i);
        end
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_i)
      dist_q.push_back(segment_distance(s_axis_tdata_i));
  end
endmodule

### tb/sv/segment_to_segment_distance_tb.sv
// Testbench top: drives segment pairs and thresholds, stalls the output, reports the verdict.
`timescale 1ns / 100ps

module segment_to_segment_distance_tb;

  localparam int CW          = segdist_pkg::CW;
  localparam int NIN         = segdist_pkg::NIN;
  localparam int TW          = segdist_pkg::TW;
  localparam int CFG_IW      = segdist_pkg::CFG_IW;
  localparam int TDATA_IN_W  = segdist_pkg::TDATA_IN_W;
  localparam int TDATA_OUT_W = segdist_pkg::TDATA_OUT_W;

  logic                   clk_i, rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IW-1:0]      cfg_idx_i;
  logic [TW-1:0]          cfg_data_i;
  logic                   s_axis_tvalid_i, s_axis_tready_o;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o, m_axis_tready_i;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  int                     fail_count, pending;
  int                     send_idle, recv_stall, hold_off;
  longint                 cycles;

  segment_to_segment_distance dut (.*);

  segment_to_segment_distance_checker checker_u (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("segment_to_segment_distance_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [CW-1:0] pick_coord(int mode);
    case (mode)
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return CW'($urandom_range(64) - 32);
      3: return CW'($urandom_range(4000) - 2000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [TDATA_IN_W-1:0] random_pair();
    logic [TDATA_IN_W-1:0] data;
    int mode, kind;
    data = '0;
    kind = $urandom_range(9);
    mode = $urandom_range(4);
    for (int i = 0; i < NIN; i++)
      data[i*CW +: CW] = pick_coord(($urandom_range(3) == 0) ? $urandom_range(4) : mode);
    // parallel and degenerate shapes
    if (kind == 0) begin
      for (int i = 0; i < 3; i++)
        data[(9+i)*CW +: CW] = data[(6+i)*CW +: CW] + data[(3+i)*CW +: CW]
                               - data[i*CW +: CW];
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) data[(3+i)*CW +: CW] = data[i*CW +: CW];
    end else if (kind == 2) begin
      for (int i = 0; i < 6; i++) data[(6+i)*CW +: CW] = data[i*CW +: CW];
    end
    return data;
  endfunction

  task automatic send_pair(logic [TDATA_IN_W-1:0] data);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= data;
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (pending > 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [TW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [TDATA_IN_W-1:0] data;
    logic [TW-1:0] thr_set[5];
    thr_set = '{16'd66, 16'd0, 16'hFFFF, 16'd1, 16'd3000};
    rst_ni = 1'b0;
    cycles = 0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0; m_axis_tready_i = 1'b0;
    send_idle = 0; recv_stall = 0; hold_off = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero, parallel, skew, degenerate
    send_pair('0);
    for (int m = 0; m < 2; m++) begin
      data = '0;
      for (int i = 0; i < NIN; i++) data[i*CW +: CW] = pick_coord(m);
      send_pair(data);
    end
    data = '0;
    for (int i = 0; i < NIN; i++) data[i*CW +: CW] = (i % 2) ? 20'h80000 : 20'h7FFFF;
    send_pair(data);
    data = '0;
    for (int i = 0; i < NIN; i++) data[i*CW +: CW] = (i < 6) ? 20'h80000 : 20'h7FFFF;
    send_pair(data);
    data = '0;
    for (int i = 0; i < NIN; i++) data[i*CW +: CW] = ~CW'(i % 4);
    send_pair(data);
    for (int k = 0; k < 12; k++) send_pair(random_pair());

    // Hold off the receiver while the sender keeps offering
    hold_off = 200;
    for (int k = 0; k < 80; k++) send_pair(random_pair());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(segdist_pkg::REG_PARALLEL, thr_set[ph]);
      write_reg(segdist_pkg::REG_ZERO, thr_set[(ph + 2) % 5]);
      for (int g = 0; g < 4; g++) begin
        send_idle = (g == 1 || g == 3) ? ((g == 3) ? 11 : 74) : 0;
        recv_stall = (g == 2 || g == 3) ? ((g == 3) ? 11 : 74) : 0;
        for (int k = 0; k < 28; k++) send_pair(random_pair());
      end
      drain();
    end

    send_idle = 0; recv_stall = 0;
    drain();
    if (fail_count == 0) begin
      $display("segment_to_segment_distance_tb OK");
    end else begin
      $display("segment_to_segment_distance_tb NOT OK");
    end
    $finish;
  end
endmodule
